FILE: rtl/lcdnf_pkg.sv
// Package for the character-LCD number formatter: item structs, mode codes,
// LCD command bytes and character helpers. No dependencies.
package lcdnf_pkg;

   localparam int LCDNF_MAX_DIGITS = 16;
   localparam int BIN_BITS         = 16;
   localparam int BCD_DIGITS       = 5;

   localparam logic [2:0] MODE_INIT = 3'd0;
   localparam logic [2:0] MODE_CHAR = 3'd1;
   localparam logic [2:0] MODE_DEC  = 3'd2;
   localparam logic [2:0] MODE_HEX  = 3'd3;
   localparam logic [2:0] MODE_BIN  = 3'd4;

   localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
   localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0c;
   localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
   localparam logic [7:0] CMD_CLEAR        = 8'h01;
   localparam logic [7:0] CMD_SET_DDRAM    = 8'h80;
   localparam logic [7:0] LINE2_OFFSET     = 8'h40;

   localparam logic [7:0] ASCII_ZERO       = 8'h30;
   localparam logic [7:0] ASCII_A_MINUS_10 = 8'h37;

   localparam logic [1:0] FIRST_LINE = 2'd1;

   localparam logic RS_COMMAND = 1'b0;
   localparam logic RS_DATA    = 1'b1;

   typedef struct packed {
      logic [2:0]  mode;
      logic [1:0]  line;
      logic [4:0]  column;
      logic [15:0] number;
      logic [4:0]  digit_count;
      logic [7:0]  character;
   } req_type;

   typedef struct packed {
      logic       reg_select;
      logic [7:0] bus_byte;
      logic       last;
   } rsp_type;

   function automatic logic [7:0] init_cmd(input logic [1:0] idx);
      logic [7:0] cmd;
      unique case (idx)
         2'd0: cmd = CMD_FUNCTION_SET;
         2'd1: cmd = CMD_DISPLAY_ON;
         2'd2: cmd = CMD_ENTRY_MODE;
         default: cmd = CMD_CLEAR;
      endcase
      return cmd;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = ASCII_ZERO + {4'b0, d};
      end else begin
         c = ASCII_A_MINUS_10 + {4'b0, d};
      end
      return c;
   endfunction

endpackage

FILE: rtl/lcdnf_bcd.sv
// Iterative binary-to-BCD converter (shift and add-3), one bit per cycle.
// Depends on lcdnf_pkg for BIN_BITS and BCD_DIGITS.
module lcdnf_bcd (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    load,
   input  logic [lcdnf_pkg::BIN_BITS-1:0]          value,
   output logic                                    done,
   output logic [4*lcdnf_pkg::BCD_DIGITS-1:0]      bcd
);
   import lcdnf_pkg::*;

   localparam int SHIFT_BITS = 4 * BCD_DIGITS + BIN_BITS;
   localparam int CNT_BITS   = $clog2(BIN_BITS + 1);

   logic [SHIFT_BITS-1:0] shift_ff, shift_in, adjusted;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;

   // add 3 to every BCD digit of 5 or more, then shift in the next bit
   always_comb begin
      adjusted = shift_ff;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (shift_ff[BIN_BITS + 4*i +: 4] >= 4'd5) begin
            adjusted[BIN_BITS + 4*i +: 4] = shift_ff[BIN_BITS + 4*i +: 4] + 4'd3;
         end
      end
   end

   always_comb begin
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         shift_in = {{(4*BCD_DIGITS){1'b0}}, value};
         cnt_in   = CNT_BITS'(BIN_BITS);
      end else if (cnt_ff != '0) begin
         shift_in = {adjusted[SHIFT_BITS-2:0], 1'b0};
         cnt_in   = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      shift_ff <= shift_in;
   end

   assign done = (cnt_ff == '0);
   assign bcd  = shift_ff[SHIFT_BITS-1:BIN_BITS];

endmodule

FILE: rtl/lcd_number_formatter.sv
// Top level of the character-LCD number formatter: request sequencer and
// write generator. Depends on lcdnf_pkg and lcdnf_bcd.
//
//   channel   ports                       direction  handshake
//   request   start, busy, req_item       in         taken when start && !busy
//   result    rsp_strobe, rsp_item        out        one cycle per item, no stall
//
// One request yields 4 writes (init), 2 (char) or 1 + the saturated digit count
// (number modes); one write leaves per cycle once emission starts. Decimal
// requests first run the shared shift/add-3 converter through every bit of the
// number; busy stays high while an item is being converted or emitted.
// Modes above binary are dropped in the accepting cycle with no write.
// Reset (synchronous, active high) returns the sequencer to idle and clears the
// strobe. The receiver cannot stall; results simply stream out.
module lcd_number_formatter #(
   parameter int MAX_DIGITS = lcdnf_pkg::LCDNF_MAX_DIGITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  lcdnf_pkg::req_type req_item,
   output logic               rsp_strobe,
   output lcdnf_pkg::rsp_type rsp_item
);
   import lcdnf_pkg::*;

   localparam logic [4:0] MaxCount = 5'(MAX_DIGITS);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CONV = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   state_type  state_ff, state_in;
   req_type    req_ff, req_in;
   logic [4:0] count_ff, count_in;   // saturated digit count
   logic [4:0] step_ff, step_in;     // index of the write within the run
   logic       rsp_strobe_ff, rsp_strobe_in;
   rsp_type    rsp_item_ff, rsp_item_in;

   logic       accept;
   logic       bcd_done;
   logic [4*BCD_DIGITS-1:0] bcd;

   rsp_type    entry;
   logic [4:0] last_idx;
   logic [4:0] pos_wide;
   logic [3:0] pos;
   logic [7:0] cursor_addr;
   logic [7:0] digit;

   assign accept = start && (state_ff == S_IDLE);

   // shared converter: load on every accepted item, only decimal waits on it
   lcdnf_bcd u_bcd (
      .clock (clock),
      .reset (reset),
      .load  (accept),
      .value (req_item.number),
      .done  (bcd_done),
      .bcd   (bcd)
   );

   // digit position counts down from the most significant requested digit
   assign pos_wide = count_ff - step_ff;
   assign pos      = pos_wide[3:0];

   always_comb begin
      priority if (req_ff.mode == MODE_DEC) begin
         if (pos >= 4'(BCD_DIGITS)) begin
            digit = ASCII_ZERO;
         end else begin
            digit = ASCII_ZERO + {4'b0, bcd[{pos[2:0], 2'b00} +: 4]};
         end
      end else if (req_ff.mode == MODE_HEX) begin
         if (pos >= 4'd4) begin
            digit = ASCII_ZERO;
         end else begin
            digit = hex_char(req_ff.number[{pos[1:0], 2'b00} +: 4]);
         end
      end else begin
         digit = ASCII_ZERO + {7'b0, req_ff.number[pos]};
      end
   end

   // column counts from 1; column zero wraps, as the bus byte is 8 bits
   assign cursor_addr = {3'b0, req_ff.column} - 8'd1
                        + ((req_ff.line != FIRST_LINE) ? LINE2_OFFSET : 8'h00);

   // build the write for the current step
   always_comb begin
      priority if (req_ff.mode == MODE_INIT) begin
         last_idx = 5'd3;
      end else if (req_ff.mode == MODE_CHAR) begin
         last_idx = 5'd1;
      end else begin
         last_idx = count_ff;
      end

      priority if (req_ff.mode == MODE_INIT) begin
         entry.reg_select = RS_COMMAND;
         entry.bus_byte   = init_cmd(step_ff[1:0]);
      end else if (step_ff == 5'd0) begin
         entry.reg_select = RS_COMMAND;
         entry.bus_byte   = CMD_SET_DDRAM | cursor_addr;
      end else if (req_ff.mode == MODE_CHAR) begin
         entry.reg_select = RS_DATA;
         entry.bus_byte   = req_ff.character;
      end else begin
         entry.reg_select = RS_DATA;
         entry.bus_byte   = digit;
      end
      entry.last = (step_ff == last_idx);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      unique case (state_ff)
         S_IDLE: begin
            // drop requests with a mode that means nothing
            if (accept && (req_item.mode <= MODE_BIN)) begin
               req_in   = req_item;
               count_in = (req_item.digit_count > MaxCount) ? MaxCount
                                                            : req_item.digit_count;
               step_in  = 5'd0;
               state_in = (req_item.mode == MODE_DEC) ? S_CONV : S_EMIT;
            end
         end
         S_CONV: begin
            // hold until the converter has shifted in every bit
            if (bcd_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // emit one write and advance
            rsp_strobe_in = 1'b1;
            rsp_item_in   = entry;
            step_in       = step_ff + 5'd1;
            if (entry.last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff      <= req_in;
      count_ff    <= count_in;
      step_ff     <= step_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for lcd_number_formatter: drives display requests and
// checks every LCD bus write against a predicted write stream.
// Depends on lcdnf_pkg and the lcd_number_formatter RTL.

class lcd_write_board;
   lcdnf_pkg::rsp_type expected_writes[$];
   int                 errors = 0;

   // ASCII digit at a position (0 is least significant) of a number in a mode
   function automatic logic [7:0] digit_char(logic [2:0] mode, logic [15:0] num, int pos);
      int unsigned value;
      logic [3:0]  nibble;
      value = num;
      if (mode == lcdnf_pkg::MODE_DEC) begin
         // the 16-bit value has only five decimal digits
         if (pos >= 5) begin
            return lcdnf_pkg::ASCII_ZERO;
         end
         repeat (pos) value = value / 10;
         return lcdnf_pkg::ASCII_ZERO + 8'(value % 10);
      end
      if (mode == lcdnf_pkg::MODE_HEX) begin
         if (pos >= 4) begin
            return lcdnf_pkg::ASCII_ZERO;
         end
         nibble = 4'((value >> (4 * pos)) & 32'hF);
         if (nibble < 4'd10) begin
            return lcdnf_pkg::ASCII_ZERO + {4'b0, nibble};
         end
         return 8'h41 + {4'b0, nibble} - 8'd10;
      end
      if (pos >= 16) begin
         return lcdnf_pkg::ASCII_ZERO;
      end
      return lcdnf_pkg::ASCII_ZERO + 8'((value >> pos) & 32'h1);
   endfunction

   // Work out the bus writes of one accepted request and queue them
   function void note_request(lcdnf_pkg::req_type r);
      lcdnf_pkg::rsp_type run[$];
      lcdnf_pkg::rsp_type w;
      logic [7:0]         addr;
      int                 count;
      if (r.mode > lcdnf_pkg::MODE_BIN) begin
         return;
      end
      w.last = 1'b0;
      if (r.mode == lcdnf_pkg::MODE_INIT) begin
         w.reg_select = lcdnf_pkg::RS_COMMAND;
         w.bus_byte   = lcdnf_pkg::CMD_FUNCTION_SET; run.push_back(w);
         w.bus_byte   = lcdnf_pkg::CMD_DISPLAY_ON;   run.push_back(w);
         w.bus_byte   = lcdnf_pkg::CMD_ENTRY_MODE;   run.push_back(w);
         w.bus_byte   = lcdnf_pkg::CMD_CLEAR;        run.push_back(w);
      end else begin
         // cursor command; column zero wraps to the top of the address range
         addr = {3'b0, r.column} - 8'd1;
         if (r.line != lcdnf_pkg::FIRST_LINE) begin
            addr = addr + lcdnf_pkg::LINE2_OFFSET;
         end
         w.reg_select = lcdnf_pkg::RS_COMMAND;
         w.bus_byte   = lcdnf_pkg::CMD_SET_DDRAM | addr;
         run.push_back(w);
         w.reg_select = lcdnf_pkg::RS_DATA;
         if (r.mode == lcdnf_pkg::MODE_CHAR) begin
            w.bus_byte = r.character;
            run.push_back(w);
         end else begin
            count = r.digit_count;
            if (count > lcdnf_pkg::LCDNF_MAX_DIGITS) begin
               count = lcdnf_pkg::LCDNF_MAX_DIGITS;
            end
            for (int i = count - 1; i >= 0; i--) begin
               w.bus_byte = digit_char(r.mode, r.number, i);
               run.push_back(w);
            end
         end
      end
      run[run.size() - 1].last = 1'b1;
      foreach (run[i]) expected_writes.push_back(run[i]);
   endfunction

   // Compare one observed write with the oldest expected one
   function void check_write(lcdnf_pkg::rsp_type got);
      lcdnf_pkg::rsp_type want;
      if (expected_writes.size() == 0) begin
         $display("%0t: unexpected write rs=%0b byte=%02h last=%0b",
                  $time, got.reg_select, got.bus_byte, got.last);
         errors++;
         return;
      end
      want = expected_writes.pop_front();
      if (got.reg_select !== want.reg_select) begin
         $display("%0t: reg_select expected %0b actual %0b",
                  $time, want.reg_select, got.reg_select);
         errors++;
      end
      if (got.bus_byte !== want.bus_byte) begin
         $display("%0t: bus_byte expected %02h actual %02h",
                  $time, want.bus_byte, got.bus_byte);
         errors++;
      end
      if (got.last !== want.last) begin
         $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
         errors++;
      end
   endfunction

   function int pending();
      return expected_writes.size();
   endfunction
endclass

module tb;
   import lcdnf_pkg::*;

   localparam int RANDOM_ITEMS = 400;
   localparam int TAIL_CYCLES  = 40;
   localparam int DRAIN_LIMIT  = 5000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   lcd_write_board board = new;

   lcd_number_formatter i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #6 clock = ~clock;

   // Writes cannot be held off: take each strobed write at the edge ending its cycle
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         board.check_write(rsp_item);
      end
   end

   // Present one item, hold it until the block takes it, then idle for gap cycles.
   // With gap zero start stays high so the next item follows back to back.
   task automatic drive_request(input req_type r, input int gap);
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy !== 1'b0);
      board.note_request(r);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold the sender until every queued write has come out or DRAIN_LIMIT runs out
   task automatic wait_drained();
      int waited;
      waited = 0;
      while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   function automatic req_type make_request(logic [2:0] mode, logic [1:0] line,
                                            logic [4:0] column, logic [15:0] number,
                                            logic [4:0] digit_count, logic [7:0] character);
      req_type r;
      r.mode        = mode;
      r.line        = line;
      r.column      = column;
      r.number      = number;
      r.digit_count = digit_count;
      r.character   = character;
      return r;
   endfunction

   // Mostly well-formed requests with random content, some out-of-range fields
   function automatic req_type random_request();
      req_type r;
      r.mode = ($urandom_range(0, 99) < 92) ? 3'($urandom_range(0, 4))
                                            : 3'($urandom_range(5, 7));
      r.line = ($urandom_range(0, 99) < 80) ? 2'($urandom_range(1, 2))
                                            : 2'($urandom_range(0, 3));
      r.column = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(1, 16))
                                              : 5'($urandom_range(0, 31));
      r.digit_count = ($urandom_range(0, 99) < 80) ? 5'($urandom_range(1, 16))
                                                   : 5'($urandom_range(0, 31));
      case ($urandom_range(0, 9))
         0: r.number = 16'h0000;
         1: r.number = 16'hFFFF;
         default: r.number = 16'($urandom);
      endcase
      r.character = 8'($urandom);
      return r;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         return 0;
      end else if (roll < 85) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   initial begin
      req_type directed[$];
      req_type r;
      int      counted;
      int      burst_left;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, every mode, cursor wrap, digit saturation, bad modes
      directed.push_back(make_request(MODE_INIT, 2'd1, 5'd1, 16'h0000, 5'd0, 8'h00));
      directed.push_back(make_request(MODE_INIT, 2'd3, 5'd31, 16'hFFFF, 5'd31, 8'hFF));
      directed.push_back(make_request(MODE_CHAR, 2'd1, 5'd1, 16'h0000, 5'd0, 8'h00));
      directed.push_back(make_request(MODE_CHAR, 2'd2, 5'd16, 16'hFFFF, 5'd31, 8'hFF));
      directed.push_back(make_request(MODE_CHAR, 2'd1, 5'd0, 16'h1234, 5'd3, 8'h41));
      directed.push_back(make_request(MODE_CHAR, 2'd2, 5'd0, 16'h1234, 5'd3, 8'h5A));
      directed.push_back(make_request(MODE_CHAR, 2'd0, 5'd31, 16'h0000, 5'd1, 8'h7E));
      directed.push_back(make_request(MODE_CHAR, 2'd3, 5'd17, 16'h0000, 5'd1, 8'hA5));
      directed.push_back(make_request(MODE_DEC, 2'd1, 5'd1, 16'hFFFF, 5'd5, 8'h00));
      directed.push_back(make_request(MODE_DEC, 2'd2, 5'd1, 16'hFFFF, 5'd16, 8'hFF));
      directed.push_back(make_request(MODE_DEC, 2'd1, 5'd8, 16'h0000, 5'd1, 8'h00));
      directed.push_back(make_request(MODE_DEC, 2'd1, 5'd4, 16'd12345, 5'd0, 8'h00));
      directed.push_back(make_request(MODE_DEC, 2'd2, 5'd2, 16'd54321, 5'd31, 8'h00));
      directed.push_back(make_request(MODE_DEC, 2'd1, 5'd3, 16'd9, 5'd6, 8'h00));
      directed.push_back(make_request(MODE_HEX, 2'd1, 5'd1, 16'hFFFF, 5'd4, 8'h00));
      directed.push_back(make_request(MODE_HEX, 2'd2, 5'd5, 16'hABCD, 5'd16, 8'h00));
      directed.push_back(make_request(MODE_HEX, 2'd1, 5'd9, 16'h0000, 5'd8, 8'h00));
      directed.push_back(make_request(MODE_HEX, 2'd2, 5'd16, 16'h9A3F, 5'd17, 8'h00));
      directed.push_back(make_request(MODE_BIN, 2'd1, 5'd1, 16'hFFFF, 5'd16, 8'h00));
      directed.push_back(make_request(MODE_BIN, 2'd2, 5'd1, 16'hA5A5, 5'd31, 8'h00));
      directed.push_back(make_request(MODE_BIN, 2'd1, 5'd12, 16'h0000, 5'd17, 8'h00));
      directed.push_back(make_request(MODE_BIN, 2'd3, 5'd7, 16'h5A5A, 5'd0, 8'h00));
      directed.push_back(make_request(3'd5, 2'd1, 5'd1, 16'h1111, 5'd4, 8'h11));
      directed.push_back(make_request(3'd6, 2'd2, 5'd2, 16'h2222, 5'd4, 8'h22));
      directed.push_back(make_request(3'd7, 2'd3, 5'd31, 16'hFFFF, 5'd31, 8'hFF));
      foreach (directed[i]) drive_request(directed[i], (i % 3 == 2) ? 2 : 0);

      // Pause until the directed writes are all out
      start <= 1'b0;
      wait_drained();
      @(posedge clock);

      // Random: ignored modes do not count toward the item total
      counted    = 0;
      burst_left = 0;
      while (counted < RANDOM_ITEMS) begin
         r = random_request();
         if (r.mode <= MODE_BIN) begin
            counted++;
         end
         if (burst_left == 0 && $urandom_range(0, 99) < 5) begin
            burst_left = $urandom_range(10, 40);
         end
         if (burst_left > 0) begin
            burst_left--;
            drive_request(r, 0);
         end else begin
            drive_request(r, pick_gap());
         end
         // Now and then hold the sender until the block has drained
         if (burst_left == 0 && $urandom_range(0, 99) < 3) begin
            start <= 1'b0;
            wait_drained();
            @(posedge clock);
         end
      end

      start <= 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (board.pending() != 0) begin
         $display("%0t: %0d expected writes never came", $time, board.pending());
         board.errors++;
      end
      if (board.errors == 0) begin
         $display("PASS lcd_number_formatter");
      end else begin
         $display("FAIL lcd_number_formatter");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #(12 * 400000);
      $display("FAIL lcd_number_formatter");
      $finish;
   end
endmodule

FILE: sim.f
rtl/lcdnf_pkg.sv
rtl/lcdnf_bcd.sv
rtl/lcd_number_formatter.sv
tb/tb.sv
